### rtl/mkdpc_pkg.sv
// Shared types and constants for the multi-key debounce and press classifier.
`default_nettype none
package mkdpc_pkg;

  localparam int KEY_COUNT = 5;
  localparam int KEY_W     = 3;
  localparam int KINDS     = 4;
  localparam int EV_SLOTS  = KEY_COUNT * KINDS;
  localparam int SLOT_W    = $clog2(EV_SLOTS);
  localparam int CNT_W     = 4;
  localparam int PADDR_W   = 4;
  localparam int PDATA_W   = 32;

  localparam logic [CNT_W-1:0] RESULT_CAP = 4'd10;

  localparam logic [7:0]  DEBOUNCE_RST = 8'd3;
  localparam logic [15:0] LONG_RST     = 16'd80;
  localparam logic [15:0] HOLD_MAX     = 16'hFFFF;

  localparam logic CMD_SCAN = 1'b0;
  localparam logic CMD_INIT = 1'b1;

  localparam logic [1:0] EV_PRESSED  = 2'd0;
  localparam logic [1:0] EV_LONG     = 2'd1;
  localparam logic [1:0] EV_SHORT    = 2'd2;
  localparam logic [1:0] EV_RELEASED = 2'd3;

  localparam logic [1:0] REG_DEBOUNCE = 2'd0;
  localparam logic [1:0] REG_LONG     = 2'd1;
  localparam logic [1:0] REG_MAX_EV   = 2'd2;

  typedef enum logic [3:0] {
    PH_RELEASED    = 4'b0001,
    PH_DEB_PRESS   = 4'b0010,
    PH_PRESSED     = 4'b0100,
    PH_DEB_RELEASE = 4'b1000
  } phase_t;

endpackage
`default_nettype wire

### rtl/mkdpc_if.sv
// Valid/ready channel interfaces for key samples and press events.
`default_nettype none
interface mkdpc_in_if;
  import mkdpc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 command;
  logic [KEY_COUNT-1:0] pressed_bits;
  modport source (output valid, command, pressed_bits, input ready);
  modport sink (input valid, command, pressed_bits, output ready);
endinterface

interface mkdpc_out_if;
  import mkdpc_pkg::*;
  logic             valid;
  logic             ready;
  logic [KEY_W-1:0] key_index;
  logic [1:0]       event_kind;
  logic             last_event;
  modport source (output valid, key_index, event_kind, last_event, input ready);
  modport sink (input valid, key_index, event_kind, last_event, output ready);
endinterface
`default_nettype wire

### rtl/multi_key_debounce_press_classifier_core.sv
// Top level: per-key debounce state, press classification and event drain.
//
// in_chan carries one beat per scan tick or init sample: command and one
// pressed bit per key. out_chan carries one beat per event: key_index,
// event_kind and last_event, which marks the final event of a tick.
// Registers sit behind an APB-style port: debounce_scans at 0x0,
// long_press_scans at 0x4, the per-tick event limit at 0x8; pready is high.
// An accepted beat lands in an input register; the step then updates all
// key states at once and loads the event mask of that tick, and the drain
// then moves the first event into the output register. The drain hands
// one event per cycle while the receiver takes them. Ticks and init
// samples that raise no event flow one per cycle while no drain is pending.
// in_chan stays ready while the event mask of a tick is being drained and
// takes the next beat into the input register, then drops until the last
// event of the tick leaves the drain.
// A stalled receiver holds the output register and then the drain; the
// input register fills and in_chan.ready drops. Reset clears all keys to
// released, empties every stage and restores the register defaults.
`default_nettype none
module multi_key_debounce_press_classifier_core (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  mkdpc_in_if.sink                           in_chan,
  mkdpc_out_if.source                        out_chan,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [mkdpc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [mkdpc_pkg::PDATA_W-1:0] pwdata,
  output logic      [mkdpc_pkg::PDATA_W-1:0] prdata,
  output logic                               pready
);
  import mkdpc_pkg::*;

  logic [7:0]       deb_scans_r;
  logic [15:0]      long_scans_r;
  logic [CNT_W-1:0] ev_limit_r;
  logic             cfg_wr;
  logic [1:0]       cfg_sel;

  logic                 in_v_r;
  logic                 cmd_r;
  logic [KEY_COUNT-1:0] bits_r;
  logic                 step_fire;

  phase_t      phase_r   [KEY_COUNT];
  phase_t      phase_nxt [KEY_COUNT];
  logic [7:0]  run_r     [KEY_COUNT];
  logic [7:0]  run_nxt   [KEY_COUNT];
  logic [7:0]  run_inc   [KEY_COUNT];
  logic [15:0] hold_r    [KEY_COUNT];
  logic [15:0] hold_nxt  [KEY_COUNT];
  logic [15:0] hold_inc  [KEY_COUNT];
  logic        lr_r      [KEY_COUNT];
  logic        lr_nxt    [KEY_COUNT];
  logic [EV_SLOTS-1:0] ev_mask;

  logic [CNT_W-1:0] cap;
  logic                pend_v_r;
  logic [EV_SLOTS-1:0] pend_mask_r;
  logic [CNT_W-1:0]    pend_cnt_r;
  logic [CNT_W-1:0]    pend_cap_r;
  logic [SLOT_W-1:0]   sel;
  logic [EV_SLOTS-1:0] sel_hot;
  logic [EV_SLOTS-1:0] rest_mask;
  logic [CNT_W-1:0]    cnt_inc;
  logic                drain_fire;
  logic                drain_last;
  logic                pend_done;

  logic             out_v_r;
  logic [KEY_W-1:0] out_key_r;
  logic [1:0]       out_kind_r;
  logic             out_last_r;

  // configuration port
  assign pready  = 1'b1;
  assign cfg_sel = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    case (cfg_sel)
      REG_DEBOUNCE: prdata = PDATA_W'(deb_scans_r);
      REG_LONG:     prdata = PDATA_W'(long_scans_r);
      REG_MAX_EV:   prdata = PDATA_W'(ev_limit_r);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deb_scans_r  <= DEBOUNCE_RST;
      long_scans_r <= LONG_RST;
      ev_limit_r   <= RESULT_CAP;
    end else if (cfg_wr) begin
      case (cfg_sel)
        REG_DEBOUNCE: deb_scans_r  <= pwdata[7:0];
        REG_LONG:     long_scans_r <= pwdata[15:0];
        REG_MAX_EV:   ev_limit_r   <= pwdata[CNT_W-1:0];
        default:      ;
      endcase
    end
  end

  // input register
  assign step_fire     = in_v_r && (!pend_v_r || pend_done);
  assign in_chan.ready = !in_v_r || step_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_v_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.valid && in_chan.ready) begin
      cmd_r  <= in_chan.command;
      bits_r <= in_chan.pressed_bits;
    end
  end

  // per-key phase machines
  always_comb begin
    for (int i = 0; i < KEY_COUNT; i++) begin
      run_inc[i]  = 8'(run_r[i] + 8'd1);
      hold_inc[i] = (hold_r[i] == HOLD_MAX) ? hold_r[i] : 16'(hold_r[i] + 16'd1);
    end
  end

  always_comb begin
    ev_mask = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      phase_nxt[i] = phase_r[i];
      run_nxt[i]   = run_r[i];
      hold_nxt[i]  = hold_r[i];
      lr_nxt[i]    = lr_r[i];
      if (cmd_r == CMD_INIT) begin
        phase_nxt[i] = bits_r[i] ? PH_PRESSED : PH_RELEASED;
        run_nxt[i]   = '0;
        hold_nxt[i]  = '0;
        lr_nxt[i]    = bits_r[i];
      end else begin
        case (phase_r[i])
          PH_RELEASED: begin
            if (bits_r[i]) begin
              phase_nxt[i] = PH_DEB_PRESS;
              run_nxt[i]   = '0;
            end
          end
          PH_DEB_PRESS: begin
            if (!bits_r[i]) begin
              phase_nxt[i] = PH_RELEASED;
              run_nxt[i]   = '0;
            end else if (run_inc[i] >= deb_scans_r) begin
              phase_nxt[i] = PH_PRESSED;
              run_nxt[i]   = '0;
              hold_nxt[i]  = '0;
              lr_nxt[i]    = 1'b0;
              ev_mask[KINDS*i + int'(EV_PRESSED)] = 1'b1;
            end else begin
              run_nxt[i] = run_inc[i];
            end
          end
          PH_PRESSED: begin
            if (!bits_r[i]) begin
              phase_nxt[i] = PH_DEB_RELEASE;
              run_nxt[i]   = '0;
            end else if (!lr_r[i]) begin
              hold_nxt[i] = hold_inc[i];
              if (hold_inc[i] >= long_scans_r) begin
                lr_nxt[i] = 1'b1;
                ev_mask[KINDS*i + int'(EV_LONG)] = 1'b1;
              end
            end
          end
          PH_DEB_RELEASE: begin
            if (bits_r[i]) begin
              phase_nxt[i] = PH_PRESSED;
              run_nxt[i]   = '0;
            end else if (run_inc[i] >= deb_scans_r) begin
              phase_nxt[i] = PH_RELEASED;
              run_nxt[i]   = '0;
              hold_nxt[i]  = '0;
              lr_nxt[i]    = 1'b0;
              ev_mask[KINDS*i + int'(EV_SHORT)]    = !lr_r[i];
              ev_mask[KINDS*i + int'(EV_RELEASED)] = 1'b1;
            end else begin
              run_nxt[i] = run_inc[i];
            end
          end
          default: begin
            phase_nxt[i] = PH_RELEASED;
            run_nxt[i]   = '0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        phase_r[i] <= PH_RELEASED;
        run_r[i]   <= '0;
        hold_r[i]  <= '0;
        lr_r[i]    <= 1'b0;
      end
    end else if (step_fire) begin
      for (int i = 0; i < KEY_COUNT; i++) begin
        phase_r[i] <= phase_nxt[i];
        run_r[i]   <= run_nxt[i];
        hold_r[i]  <= hold_nxt[i];
        lr_r[i]    <= lr_nxt[i];
      end
    end
  end

  // event drain
  assign cap = (ev_limit_r > RESULT_CAP) ? RESULT_CAP : ev_limit_r;

  always_comb begin
    sel = '0;
    for (int j = EV_SLOTS - 1; j >= 0; j--) begin
      if (pend_mask_r[j]) begin
        sel = SLOT_W'(j);
      end
    end
  end

  assign sel_hot    = EV_SLOTS'(1) << sel;
  assign rest_mask  = pend_mask_r & ~sel_hot;
  assign cnt_inc    = CNT_W'(pend_cnt_r + 4'd1);
  assign drain_fire = pend_v_r && (!out_v_r || out_chan.ready);
  assign drain_last = (rest_mask == '0) || (cnt_inc == pend_cap_r);
  assign pend_done  = drain_fire && drain_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r <= 1'b0;
    end else if (step_fire && (cmd_r == CMD_SCAN) && (ev_mask != '0) && (cap != '0)) begin
      pend_v_r <= 1'b1;
    end else if (pend_done) begin
      pend_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_fire) begin
      pend_mask_r <= ev_mask;
      pend_cnt_r  <= '0;
      pend_cap_r  <= cap;
    end else if (drain_fire) begin
      pend_mask_r <= rest_mask;
      pend_cnt_r  <= cnt_inc;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (drain_fire) begin
      out_v_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_fire) begin
      out_key_r  <= sel[SLOT_W-1:2];
      out_kind_r <= sel[1:0];
      out_last_r <= drain_last;
    end
  end

  assign out_chan.valid      = out_v_r;
  assign out_chan.key_index  = out_key_r;
  assign out_chan.event_kind = out_kind_r;
  assign out_chan.last_event = out_last_r;

endmodule
`default_nettype wire

### rtl/mkdpc_checker.sv
// Port-level checks for the press classifier, bound to the top level.
`default_nettype none
module mkdpc_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [mkdpc_pkg::KEY_W-1:0]  out_key_index,
  input wire logic [1:0]                   out_event_kind,
  input wire logic                         out_last_event,
  input wire logic                         pready
);
  import mkdpc_pkg::*;

  a_reset_empties_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("event beat right after reset");

  a_reset_frees_in: assert property (@(posedge clk)
    !rst_n |=> in_ready)
    else $error("input not ready right after reset");

  a_key_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_key_index < KEY_W'(KEY_COUNT)))
    else $error("event for a key that does not exist");

  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_key_index)
      && $stable(out_event_kind) && $stable(out_last_event))
    else $error("stalled event beat changed");

  a_pready_high: assert property (@(posedge clk) disable iff (!rst_n)
    pready)
    else $error("configuration port inserted a wait state");

endmodule

bind multi_key_debounce_press_classifier_core mkdpc_checker u_mkdpc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_chan.ready),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .out_key_index  (out_chan.key_index),
  .out_event_kind (out_chan.event_kind),
  .out_last_event (out_chan.last_event),
  .pready         (pready)
);
`default_nettype wire
